FILE: rtl/fatan2_pkg.sv
// Shared constants and types for the fast four-quadrant arctangent pipeline
package fatan2_pkg;

	localparam int IN_WIDTH_DEF   = 16;
	localparam int FRAC           = 16;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = FRAC / BITS_PER_STAGE;
	localparam int ANGLE_W        = 16;
	localparam int R_W            = 18;

	localparam logic [15:0] C1_MAG = 16'd21471;
	localparam logic [15:0] C2_MAG = 16'd10441;
	localparam logic [15:0] C3_MAG = 16'd3047;
	localparam logic [R_W-1:0] HALF_PI_Q16 = 18'd102944;
	localparam logic [R_W-1:0] PI_Q16      = 18'd205887;
	localparam logic [R_W-1:0] ROUND_HALF  = 18'd4;

	typedef struct packed {
		logic swap;
		logic xneg;
		logic yneg;
		logic zero;
		logic eq;
	} flags_t;

endpackage

FILE: rtl/fatan2_if.sv
// Valid/ready channel interfaces for vectors in and angles out
interface fatan2_in_if #(
	parameter int IN_WIDTH = fatan2_pkg::IN_WIDTH_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] x_in;
	logic signed [IN_WIDTH-1:0] y_in;

	modport source (output valid, output x_in, output y_in, input ready);
	modport sink (input valid, input x_in, input y_in, output ready);
endinterface

interface fatan2_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fatan2_pkg::ANGLE_W-1:0] angle;
	logic                                   undefined;

	modport source (output valid, output angle, output undefined, input ready);
	modport sink (input valid, input angle, input undefined, output ready);
endinterface

FILE: rtl/fast_atan2_approximation.sv
// Pipelined four-quadrant arctangent of a signed vector, Q3.13 radian output
//
// Channel vec carries one vector (x_in, y_in) per transfer; channel res returns
// one angle per vector, in order, as Q3.13 radians in -pi..pi. When both
// components are zero, angle is 0 and undefined is 1.
// The pipeline has 15 register stages: one for magnitudes and octant, eight for
// the ratio divider (two quotient bits per stage), five for the polynomial
// multiplies and one for reflection and rounding into the output register.
// Throughput: one vector per cycle while the receiver does not stall.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse: while res.ready is low, vec.ready stays high until every
// stage holds an item; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; the pipeline is empty afterwards.
module fast_atan2_approximation #(
	parameter int IN_WIDTH = fatan2_pkg::IN_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	fatan2_in_if.sink    vec,
	fatan2_out_if.source res
);

	localparam int W      = IN_WIDTH;
	localparam int FRAC   = fatan2_pkg::FRAC;
	localparam int BPS    = fatan2_pkg::BITS_PER_STAGE;
	localparam int DIV_ST = fatan2_pkg::DIV_STAGES;
	localparam int ST_M1  = DIV_ST + 1;
	localparam int ST_M2  = DIV_ST + 2;
	localparam int ST_M3  = DIV_ST + 3;
	localparam int ST_M4  = DIV_ST + 4;
	localparam int ST_M5  = DIV_ST + 5;
	localparam int ST_OUT = DIV_ST + 6;
	localparam int NUM_ST = ST_OUT + 1;
	localparam int R_W    = fatan2_pkg::R_W;
	localparam int AW     = fatan2_pkg::ANGLE_W;

	logic [NUM_ST-1:0] vld_s;
	logic [NUM_ST-1:0] adv;

	fatan2_pkg::flags_t flg_s [0:ST_OUT-1];
	logic [W-1:0]       rem_s [0:DIV_ST];
	logic [W-1:0]       hi_s  [0:DIV_ST];
	logic [FRAC-1:0]    q_s   [0:DIV_ST];

	logic [15:0] a_s10, s_s10;
	logic [15:0] a_s11, s_s11, t_s11;
	logic [15:0] a_s12, s_s12, u_s12;
	logic [15:0] a_s13, p_s13;
	logic [15:0] r_s14;
	logic signed [AW-1:0] angle_s15;
	logic                 undf_s15;

	// Stage advance: empty here or anywhere downstream, or the receiver takes
	always_comb begin
		for (int k = 0; k < NUM_ST; k++) begin
			adv[k] = res.ready | (|(~vld_s & ({NUM_ST{1'b1}} << k)));
		end
	end

	assign vec.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= vec.valid;
			end
			for (int k = 1; k < NUM_ST; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Magnitudes, octant and quadrant flags
	logic         xneg, yneg;
	logic [W-1:0] ax, ay;

	always_comb begin
		xneg = vec.x_in[W-1];
		yneg = vec.y_in[W-1];
		ax   = xneg ? W'(~vec.x_in + 1'b1) : W'(vec.x_in);
		ay   = yneg ? W'(~vec.y_in + 1'b1) : W'(vec.y_in);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0]      <= (ax < ay) ? ax : ay;
			hi_s[0]       <= (ax < ay) ? ay : ax;
			q_s[0]        <= '0;
			flg_s[0].swap <= ay > ax;
			flg_s[0].xneg <= xneg;
			flg_s[0].yneg <= yneg;
			flg_s[0].zero <= (ax == '0) && (ay == '0);
			flg_s[0].eq   <= ax == ay;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k < ST_OUT; k++) begin
			if (adv[k]) begin
				flg_s[k] <= flg_s[k-1];
			end
		end
	end

	// Restoring divider: (lo << FRAC) / hi, BPS quotient bits per stage
	for (genvar g = 0; g < DIV_ST; g++) begin : g_div
		logic [W-1:0]    rem_nx;
		logic [FRAC-1:0] q_nx;

		always_comb begin
			logic [W:0] r2;
			rem_nx = rem_s[g];
			q_nx   = q_s[g];
			for (int b = 0; b < BPS; b++) begin
				r2 = {rem_nx, 1'b0};
				if (r2 >= {1'b0, hi_s[g]}) begin
					rem_nx = W'(r2 - {1'b0, hi_s[g]});
					q_nx   = {q_nx[FRAC-2:0], 1'b1};
				end else begin
					rem_nx = r2[W-1:0];
					q_nx   = {q_nx[FRAC-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g+1]) begin
				rem_s[g+1] <= rem_nx;
				hi_s[g+1]  <= hi_s[g];
				q_s[g+1]   <= q_nx;
			end
		end
	end

	// Polynomial on magnitudes: r = a - a*s*u, u = c1 - s*(c2 - s*c3)
	logic [15:0] a_sat;
	logic [31:0] prod_m1, prod_m2, prod_m3, prod_m4, prod_m5;

	always_comb begin
		a_sat   = flg_s[DIV_ST].eq ? 16'hFFFF : q_s[DIV_ST];
		prod_m1 = 32'(a_sat) * 32'(a_sat);
		prod_m2 = 32'(s_s10) * 32'(fatan2_pkg::C3_MAG);
		prod_m3 = 32'(s_s11) * 32'(t_s11);
		prod_m4 = 32'(s_s12) * 32'(u_s12);
		prod_m5 = 32'(a_s13) * 32'(p_s13);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_M1]) begin
			a_s10 <= a_sat;
			s_s10 <= prod_m1[31:16];
		end
		if (adv[ST_M2]) begin
			a_s11 <= a_s10;
			s_s11 <= s_s10;
			t_s11 <= fatan2_pkg::C2_MAG - prod_m2[31:16];
		end
		if (adv[ST_M3]) begin
			a_s12 <= a_s11;
			s_s12 <= s_s11;
			u_s12 <= fatan2_pkg::C1_MAG - prod_m3[31:16];
		end
		if (adv[ST_M4]) begin
			a_s13 <= a_s12;
			p_s13 <= prod_m4[31:16];
		end
		if (adv[ST_M5]) begin
			r_s14 <= a_s13 - prod_m5[31:16];
		end
	end

	// Reflect into octant and quadrant, round half up to Q3.13
	logic [R_W-1:0]  r_oct, r_quad, r_rnd;
	logic [AW-1:0]   mag;
	logic [AW-1:0]   angle_nx;

	always_comb begin
		r_oct  = flg_s[ST_M5].swap ? fatan2_pkg::HALF_PI_Q16 - R_W'(r_s14) : R_W'(r_s14);
		r_quad = flg_s[ST_M5].xneg ? fatan2_pkg::PI_Q16 - r_oct : r_oct;
		r_rnd  = r_quad + fatan2_pkg::ROUND_HALF;
		mag    = AW'(r_rnd >> 3);
		if (flg_s[ST_M5].zero) begin
			angle_nx = '0;
		end else if (flg_s[ST_M5].yneg) begin
			angle_nx = ~mag + 1'b1;
		end else begin
			angle_nx = mag;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			angle_s15 <= $signed(angle_nx);
			undf_s15  <= flg_s[ST_M5].zero;
		end
	end

	assign res.valid     = vld_s[ST_OUT];
	assign res.angle     = angle_s15;
	assign res.undefined = undf_s15;

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.undefined |-> res.angle == '0)
		else $error("undefined result with nonzero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.angle <= 16'sd25736) && (res.angle >= -16'sd25736))
		else $error("angle outside -pi..pi");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> (&vld_s) && !res.ready)
		else $error("input stalled while pipeline has a bubble");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		vec.valid && vec.ready |=> vld_s[0])
		else $error("transfer did not enter first stage");

endmodule

FILE: bench/fatan2_checker.sv
// Checker for the arctangent pipeline: predicts each angle and compares it with the output
`timescale 1ns / 1ps

module fatan2_checker (
	input  logic  clk,
	input  logic  arst_n,
	fatan2_in_if  vec,
	fatan2_out_if res,
	output int    errors,
	output int    pending,
	output int    checked,
	output int    undef_seen
);

	localparam longint unsigned POLY_C1 = 21471;
	localparam longint unsigned POLY_C2 = 10441;
	localparam longint unsigned POLY_C3 = 3047;
	localparam longint unsigned QUARTER_TURN = 102944;
	localparam longint unsigned HALF_TURN = 205887;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] angle;
		logic        undefined;
	} angle_exp_t;

	angle_exp_t expected_angles[$];
	int         err_cnt;
	int         chk_cnt;
	int         undef_cnt;

	assign errors     = err_cnt;
	assign checked    = chk_cnt;
	assign undef_seen = undef_cnt;

	function automatic angle_exp_t predict_angle(input logic [15:0] x, input logic [15:0] y);
		longint unsigned ax, ay, lo, hi, a, s, t, u, p, r, mag;
		angle_exp_t e;
		e.vx = x;
		e.vy = y;
		ax = x[15] ? 64'd65536 - 64'(x) : 64'(x);
		ay = y[15] ? 64'd65536 - 64'(y) : 64'(y);
		if (ax == 0 && ay == 0) begin
			e.angle = '0;
			e.undefined = 1'b1;
			return e;
		end
		lo = (ax < ay) ? ax : ay;
		hi = (ax < ay) ? ay : ax;
		a = (lo << 16) / hi;
		if (a > 64'hFFFF)
			a = 64'hFFFF;
		s = (a * a) >> 16;
		t = POLY_C2 - ((s * POLY_C3) >> 16);
		u = POLY_C1 - ((s * t) >> 16);
		p = (s * u) >> 16;
		r = a - ((a * p) >> 16);
		if (ay > ax)
			r = QUARTER_TURN - r;
		if (x[15])
			r = HALF_TURN - r;
		mag = (r + 4) >> 3;
		e.angle = y[15] ? 16'(-mag) : 16'(mag);
		e.undefined = 1'b0;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angle_exp_t e;
		if (!arst_n) begin
			expected_angles.delete();
			err_cnt   = 0;
			chk_cnt   = 0;
			undef_cnt = 0;
			pending  <= 0;
		end else begin
			if (vec.valid && vec.ready)
				expected_angles.push_back(predict_angle(vec.x_in, vec.y_in));
			if (res.valid && res.ready) begin
				if (expected_angles.size() == 0) begin
					if (err_cnt < REPORT_MAX)
						$display("unexpected transfer: angle %0d undefined %0b",
							$signed(res.angle), res.undefined);
					err_cnt++;
				end else begin
					e = expected_angles.pop_front();
					chk_cnt++;
					if (res.undefined)
						undef_cnt++;
					if (res.angle !== e.angle || res.undefined !== e.undefined) begin
						if (err_cnt < REPORT_MAX)
							$display("mismatch x=%0d y=%0d: expected angle %0d undefined %0b, got angle %0d undefined %0b",
								$signed(e.vx), $signed(e.vy), $signed(e.angle), e.undefined,
								$signed(res.angle), res.undefined);
						err_cnt++;
					end
				end
			end
			pending <= expected_angles.size();
		end
	end

endmodule

FILE: bench/tb_fast_atan2_approximation.sv
// Top of the arctangent pipeline bench: clock, reset, vector stimulus and verdict
`timescale 1ns / 1ps

module tb_fast_atan2_approximation;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;
	int   phase;
	int   n_sent;
	int   cycles;
	bit   hold_done;
	int   errors, pending, checked, undef_seen;

	fatan2_in_if #(.IN_WIDTH(16)) vec ();
	fatan2_out_if                 res ();

	fast_atan2_approximation #(.IN_WIDTH(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec),
		.res    (res)
	);

	fatan2_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec        (vec),
		.res        (res),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.undef_seen (undef_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d angles outstanding", cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int tx_idle_pct();
		return (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
	endfunction

	function automatic int rx_idle_pct();
		return (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
	endfunction

	// Receiver: random stalls, plus one long hold-off when the no-idle phase starts
	initial begin
		res.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 2 && !hold_done) begin
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				res.ready <= ($urandom_range(99) >= rx_idle_pct());
			end
		end
	end

	task automatic send_vec(input logic [15:0] x, input logic [15:0] y);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct()) begin
			vec.valid <= 1'b0;
			vec.x_in  <= 16'($urandom);
			vec.y_in  <= 16'($urandom);
			@(negedge clk);
		end
		vec.valid <= 1'b1;
		vec.x_in  <= x;
		vec.y_in  <= y;
		@(posedge clk);
		while (!vec.ready) @(posedge clk);
		n_sent++;
	endtask

	task automatic send_random_vec();
		logic [15:0] x, y;
		int          kind;
		kind = $urandom_range(99);
		x = 16'($urandom);
		y = 16'($urandom);
		if (kind < 60) begin
		end else if (kind < 72) begin
			x = 16'($urandom_range(31)) - 16'd16;
			y = 16'($urandom_range(31)) - 16'd16;
		end else if (kind < 82) begin
			y = $urandom_range(1) ? x : -x;
		end else if (kind < 90) begin
			if ($urandom_range(1))
				x = '0;
			else
				y = '0;
		end else begin
			y = x + 16'($urandom_range(15)) - 16'd8;
		end
		send_vec(x, y);
	endtask

	initial begin
		arst_n    = 1'b0;
		phase     = 0;
		n_sent    = 0;
		vec.valid = 1'b0;
		vec.x_in  = '0;
		vec.y_in  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_vec(16'sd0, 16'sd0);
		send_vec(16'sd1, 16'sd0);
		send_vec(-16'sd1, 16'sd0);
		send_vec(16'sd0, 16'sd1);
		send_vec(16'sd0, -16'sd1);
		send_vec(16'sd32767, 16'sd0);
		send_vec(16'h8000, 16'sd0);
		send_vec(16'sd0, 16'sd32767);
		send_vec(16'sd0, 16'h8000);
		send_vec(16'h8000, 16'h8000);
		send_vec(16'sd32767, 16'sd32767);
		send_vec(16'h8000, 16'sd32767);
		send_vec(16'sd32767, 16'h8000);
		send_vec(16'sd100, 16'sd100);
		send_vec(-16'sd100, 16'sd100);
		send_vec(-16'sd100, -16'sd100);
		send_vec(-16'sd5, 16'sd0);
		send_vec(16'sd1, 16'sd32767);
		send_vec(16'sd32767, 16'sd1);
		send_vec(16'h8000, 16'sd1);
		send_vec(16'sd1, 16'h8000);
		send_vec(-16'sd1, -16'sd1);
		send_vec(16'sd12345, -16'sd6789);
		send_vec(-16'sd20000, 16'sd30000);

		repeat (140) send_random_vec();
		phase = 1;
		repeat (140) send_random_vec();
		phase = 2;
		repeat (120) send_random_vec();
		@(negedge clk);
		vec.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("%0d vectors sent over three stall patterns and one long output hold-off",
			n_sent);
		$display("%0d angles checked, %0d of them for the zero vector, %0d failures",
			checked, undef_seen, errors);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
